>>> rtl/hfe_pkg.sv
// ----------------------------------------------------------------------------
// HDLC frame encoder package
// Shared types, byte codes and the CRC-16/X.25 byte update.
// ----------------------------------------------------------------------------
package hfe_pkg;

   localparam logic [7:0]  FLAG_BYTE = 8'h7E;
   localparam logic [7:0]  ESC_BYTE  = 8'h7D;
   localparam logic [7:0]  ESC_XOR   = 8'h20;
   localparam logic [15:0] FCS_SEED  = 16'hFFFF;
   localparam logic [15:0] FCS_POLY  = 16'h8408;

   localparam logic [7:0] HEADER_ADDRESS_RESET = 8'h01;
   localparam logic [7:0] HEADER_TYPE_RESET    = 8'h03;

   // Configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_ADDRESS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_TYPE    = 1'b1;

   // Cycles the header check pipeline needs after reset or a register write
   localparam logic [1:0] HDR_SETTLE_CYCLES = 2'd2;

   // Pieces of one item's output, in line order
   localparam logic [2:0] PIECE_FLAG_OPEN  = 3'd0;
   localparam logic [2:0] PIECE_ADDRESS    = 3'd1;
   localparam logic [2:0] PIECE_TYPE       = 3'd2;
   localparam logic [2:0] PIECE_DATA       = 3'd3;
   localparam logic [2:0] PIECE_FCS_LOW    = 3'd4;
   localparam logic [2:0] PIECE_FCS_HIGH   = 3'd5;
   localparam logic [2:0] PIECE_FLAG_CLOSE = 3'd6;

   // One classified item as passed from the front to the back
   typedef struct packed {
      logic [7:0]  payload_byte;
      logic        frame_last;
      logic        frame_open;
      logic [7:0]  header_address;
      logic [7:0]  header_type;
      logic [15:0] fcs_check;
   } hfe_item_type;

   // Reflected CRC-16/X.25 update by one byte
   function automatic logic [15:0] fcs_feed(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] c;
      c = acc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ FCS_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

>>> rtl/hfe_req_if.sv
// ----------------------------------------------------------------------------
// HDLC encoder request channel
// Carries one payload byte and its end-of-frame mark per transfer.
// ----------------------------------------------------------------------------
interface hfe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       frame_last;

   modport source (output valid, output payload_byte, output frame_last, input ready);
   modport sink   (input valid, input payload_byte, input frame_last, output ready);
endinterface

>>> rtl/hfe_rsp_if.sv
// ----------------------------------------------------------------------------
// HDLC encoder response channel
// Carries one line byte per transfer and the mark of an item's last byte.
// ----------------------------------------------------------------------------
interface hfe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] line_byte;
   logic       run_last;

   modport source (output valid, output line_byte, output run_last, input ready);
   modport sink   (input valid, input line_byte, input run_last, output ready);
endinterface

>>> rtl/hfe_csr_if.sv
// ----------------------------------------------------------------------------
// HDLC encoder register write channel
// Carries a register index and write data per transfer.
// ----------------------------------------------------------------------------
interface hfe_csr_if;
   import hfe_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [7:0]           data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/hdlc_frame_encoder.sv
// An item goes through the item queue and then the output register to the line.
// Throughput: the back end sends one line byte per cycle while the response channel
// takes it; an item has 1 to 12 line bytes, and an escaped byte becomes two.
// Reset clears frame state, loads header address 1 and type 3, and holds the request
// channel while the header check pipeline fills (also after each write).
// ----------------------------------------------------------------------------
// HDLC frame encoder
// Frames payload bytes with flags, header, byte stuffing and CRC-16/X.25.
// ----------------------------------------------------------------------------
module hdlc_frame_encoder
   import hfe_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   hfe_req_if.sink   req_ch,
   hfe_rsp_if.source rsp_ch,
   hfe_csr_if.sink   csr_ch
);

   hfe_item_type push_item;
   hfe_item_type pop_item;
   logic         push_valid;
   logic         push_ready;
   logic         pop_valid;
   logic         pop_ready;

   assign csr_ch.ready = 1'b1;

   hfe_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_ch.valid),
      .req_ready    (req_ch.ready),
      .payload_byte (req_ch.payload_byte),
      .frame_last   (req_ch.frame_last),
      .csr_valid    (csr_ch.valid),
      .csr_index    (csr_ch.index),
      .csr_data     (csr_ch.data),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_item    (push_item)
   );

   hfe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   hfe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .line_byte (rsp_ch.line_byte),
      .run_last  (rsp_ch.run_last)
   );

endmodule

>>> rtl/hfe_front.sv
// ----------------------------------------------------------------------------
// HDLC encoder front end
// Holds the header registers and frame state, runs the frame check and
// classifies each accepted byte into an item record for the queue.
// ----------------------------------------------------------------------------
module hfe_front
   import hfe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           payload_byte,
   input  logic                 frame_last,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_data,
   output logic                 push_valid,
   input  logic                 push_ready,
   output hfe_item_type         push_item
);

   logic [7:0]  hdr_addr_ff, hdr_addr_in;
   logic [7:0]  hdr_type_ff, hdr_type_in;
   logic [15:0] hdr_fcs1_ff;
   logic [15:0] hdr_fcs2_ff;
   logic [1:0]  settle_ff, settle_in;
   logic        in_frame_ff, in_frame_in;
   logic [15:0] fcs_ff, fcs_in;
   logic [15:0] fcs_base;
   logic [15:0] fcs_next;
   logic        accept;

   assign req_ready  = push_ready && (settle_ff == 2'd0);
   assign push_valid = req_valid && (settle_ff == 2'd0);
   assign accept     = req_valid && req_ready;

   // The check over the header is precomputed in the header check pipeline, so an
   // opening byte needs only one byte update.
   assign fcs_base = in_frame_ff ? fcs_ff : hdr_fcs2_ff;
   assign fcs_next = fcs_feed(fcs_base, payload_byte);

   always_comb begin
      push_item.payload_byte   = payload_byte;
      push_item.frame_last     = frame_last;
      push_item.frame_open     = !in_frame_ff;
      push_item.header_address = hdr_addr_ff;
      push_item.header_type    = hdr_type_ff;
      push_item.fcs_check      = ~fcs_next;
   end

   always_comb begin
      hdr_addr_in = hdr_addr_ff;
      hdr_type_in = hdr_type_ff;
      settle_in   = (settle_ff != 2'd0) ? settle_ff - 2'd1 : settle_ff;
      if (csr_valid) begin
         settle_in = HDR_SETTLE_CYCLES;
         case (csr_index)
            CSR_HEADER_ADDRESS: hdr_addr_in = csr_data;
            CSR_HEADER_TYPE:    hdr_type_in = csr_data;
            default:            hdr_addr_in = hdr_addr_ff;
         endcase
      end
      in_frame_in = in_frame_ff;
      fcs_in      = fcs_ff;
      if (accept) begin
         in_frame_in = !frame_last;
         fcs_in      = fcs_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_addr_ff <= HEADER_ADDRESS_RESET;
         hdr_type_ff <= HEADER_TYPE_RESET;
         settle_ff   <= HDR_SETTLE_CYCLES;
         in_frame_ff <= 1'b0;
         fcs_ff      <= FCS_SEED;
      end else begin
         hdr_addr_ff <= hdr_addr_in;
         hdr_type_ff <= hdr_type_in;
         settle_ff   <= settle_in;
         in_frame_ff <= in_frame_in;
         fcs_ff      <= fcs_in;
      end
   end

   // Header check pipeline, one byte per stage
   always_ff @(posedge clock) begin
      hdr_fcs1_ff <= fcs_feed(FCS_SEED, hdr_addr_ff);
      hdr_fcs2_ff <= fcs_feed(hdr_fcs1_ff, hdr_type_ff);
   end

endmodule

>>> rtl/hfe_queue.sv
// ----------------------------------------------------------------------------
// HDLC encoder item queue
// Two-entry queue of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module hfe_queue
   import hfe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  hfe_item_type push_item,
   output logic         pop_valid,
   input  logic         pop_ready,
   output hfe_item_type pop_item
);

   hfe_item_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> rtl/hfe_back.sv
// ----------------------------------------------------------------------------
// HDLC encoder back end
// Walks the pieces of each queued item, stuffs flag and escape values and
// drives the registered output byte.
// ----------------------------------------------------------------------------
module hfe_back
   import hfe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         pop_valid,
   output logic         pop_ready,
   input  hfe_item_type pop_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [7:0]   line_byte,
   output logic         run_last
);

   logic [2:0] piece_ff, piece_in;
   logic       esc_ff, esc_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff;
   logic       out_last_ff;
   logic [2:0] piece;
   logic [2:0] final_piece;
   logic [7:0] raw;
   logic       stuffed;
   logic       need_esc;
   logic       byte_done;
   logic       item_done;
   logic [7:0] tx_byte;
   logic       out_free;
   logic       fire;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign fire      = pop_valid && out_free;

   // A byte inside an open frame starts straight at its data piece.
   assign piece = (piece_ff == PIECE_FLAG_OPEN && !pop_item.frame_open) ? PIECE_DATA
                                                                        : piece_ff;
   assign final_piece = pop_item.frame_last ? PIECE_FLAG_CLOSE : PIECE_DATA;

   always_comb begin
      stuffed = 1'b1;
      case (piece)
         PIECE_FLAG_OPEN:  begin raw = FLAG_BYTE; stuffed = 1'b0; end
         PIECE_ADDRESS:    raw = pop_item.header_address;
         PIECE_TYPE:       raw = pop_item.header_type;
         PIECE_DATA:       raw = pop_item.payload_byte;
         PIECE_FCS_LOW:    raw = pop_item.fcs_check[7:0];
         PIECE_FCS_HIGH:   raw = pop_item.fcs_check[15:8];
         PIECE_FLAG_CLOSE: begin raw = FLAG_BYTE; stuffed = 1'b0; end
         default:          begin raw = FLAG_BYTE; stuffed = 1'b0; end
      endcase
   end

   assign need_esc  = stuffed && (raw == FLAG_BYTE || raw == ESC_BYTE);
   assign byte_done = !need_esc || esc_ff;
   assign item_done = byte_done && (piece == final_piece);
   assign tx_byte   = !need_esc ? raw : (esc_ff ? (raw ^ ESC_XOR) : ESC_BYTE);
   assign pop_ready = fire && item_done;

   always_comb begin
      piece_in     = piece_ff;
      esc_in       = esc_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      if (fire) begin
         out_valid_in = 1'b1;
         esc_in       = !byte_done;
         if (byte_done) begin
            piece_in = item_done ? PIECE_FLAG_OPEN : piece + 3'd1;
         end else begin
            piece_in = piece;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         piece_ff     <= PIECE_FLAG_OPEN;
         esc_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         piece_ff     <= piece_in;
         esc_ff       <= esc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_byte_ff <= tx_byte;
         out_last_ff <= item_done;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign line_byte = out_byte_ff;
   assign run_last  = out_last_ff;

endmodule
